// ===== design/png_unf_pkg.sv =====
package png_unf_pkg;

  // Field widths fixed by the stream format.
  localparam int unsigned ByteW     = 8;
  localparam int unsigned ImgWidthW = 14;
  localparam int unsigned ImgHeightW = 16;
  localparam int unsigned BppW      = 3;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 16;

  // Pixel size code that selects RGB8 with alpha insertion.
  localparam logic [BppW-1:0] BppRgb = 3'd3;

  // Alpha byte inserted after each RGB triple.
  localparam logic [ByteW-1:0] AlphaOpaque = 8'd255;

  // Configuration register indexes.
  typedef enum logic [CfgIndexW-1:0] {
    CFG_IMAGE_WIDTH     = 2'd0,
    CFG_IMAGE_HEIGHT    = 2'd1,
    CFG_BYTES_PER_PIXEL = 2'd2
  } cfg_index_e;

  // Row filter types.
  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filter_e;

  // What the back end does with a job.
  typedef enum logic [1:0] {
    JOB_CLEAR = 2'd0,
    JOB_ERROR = 2'd1,
    JOB_PIXEL = 2'd2
  } job_kind_e;

  // Input item.
  typedef struct packed {
    logic [ByteW-1:0] filtered_byte;
    logic             frame_start;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [ByteW-1:0] pixel_byte;
    logic             last_in_run;
    logic             end_of_image;
    logic             bad_filter;
  } out_item_t;

  // Classified item handed from the front end to the back end.
  typedef struct packed {
    job_kind_e        kind;
    logic [ByteW-1:0] data;
    filter_e          filter;
    logic [1:0]       lane;
    logic             first_row;
    logic             eoi;
    logic             alpha;
  } job_t;

endpackage

// ===== design/png_scanline_unfilter_core.sv =====
// Channel  Handshake            Payload                          Direction
// -------  -------------------  -------------------------------  ---------
// input    push / full          in_item_i (byte, frame start)    in
// result   empty / pop          out_item_o (byte and flags)      out
// config   cfg_valid_i / ready  cfg_index_i, cfg_data_i          in
//
// One item is accepted per cycle while the result side keeps up; RGB rows give
// four results per three pixel bytes, so there the result port sets the pace.
// An accepted item passes through the job queue and then the compute stage behind
// the line store read before its result enters the result queue.
// Valid filter-type bytes pass through the back end and give no result.
// Reset clears counters and queues; the line store is not cleared, since the
// first row of every image reads zero for the bytes above.
module png_scanline_unfilter_core import png_unf_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 8192
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  in_item_t             in_item_i,
  output logic                 empty,
  input  logic                 pop,
  output out_item_t            out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned AddrW = $clog2(MAX_WIDTH * 4);
  localparam int unsigned JobW  = $bits(job_t) + AddrW;
  localparam int unsigned OutW  = $bits(out_item_t);

  logic             accept;
  job_t             fe_job;
  logic [AddrW-1:0] fe_addr;
  logic [JobW-1:0]  jq_head;
  logic             jq_empty;
  logic             jq_pop;
  job_t             be_job;
  logic [AddrW-1:0] be_addr;
  logic             oq_push;
  logic             oq_full;
  out_item_t        be_out;
  logic [OutW-1:0]  oq_head;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  // Front end: configuration, counters and classification.
  png_unf_front #(
    .MaxWidth (MAX_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_write_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .item_i      (in_item_i),
    .job_o       (fe_job),
    .job_addr_o  (fe_addr)
  );

  // Job queue between the front and back ends.
  png_unf_fifo #(
    .Width (JobW),
    .Depth (2)
  ) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  ({fe_job, fe_addr}),
    .pop_i   (jq_pop),
    .data_o  (jq_head),
    .full_o  (full),
    .empty_o (jq_empty)
  );

  assign be_job  = job_t'(jq_head[JobW-1:AddrW]);
  assign be_addr = jq_head[AddrW-1:0];

  // Back end: line store, neighbors and reconstruction.
  png_unf_back #(
    .MaxWidth (MAX_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!jq_empty),
    .job_i       (be_job),
    .job_addr_i  (be_addr),
    .job_pop_o   (jq_pop),
    .out_push_o  (oq_push),
    .out_item_o  (be_out),
    .out_full_i  (oq_full)
  );

  // Result queue feeding the output port.
  png_unf_fifo #(
    .Width (OutW),
    .Depth (2)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (oq_push),
    .data_i  (be_out),
    .pop_i   (pop),
    .data_o  (oq_head),
    .full_o  (oq_full),
    .empty_o (empty)
  );

  assign out_item_o = out_item_t'(oq_head);

`ifndef SYNTHESIS
  // An error result carries a zero byte and never ends the image.
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.bad_filter) |->
      (out_item_o.pixel_byte == '0) && !out_item_o.end_of_image)
    else $error("error result with nonzero byte or end of image");

  // End of image is only flagged on the last result of an item.
  a_eoi_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.end_of_image) |-> out_item_o.last_in_run)
    else $error("end of image on a result that is not last in run");

  // A result that is not last in its run is a pixel byte, not an error.
  a_first_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_item_o.last_in_run) |->
      !out_item_o.bad_filter && !out_item_o.end_of_image)
    else $error("malformed first result of a two-result run");

  // The alpha byte is ready as soon as the byte before it is taken.
  a_alpha_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !out_item_o.last_in_run) |=> !empty)
    else $error("alpha byte missing after an RGB byte");
`endif

endmodule

// ===== design/png_unf_fifo.sv =====
module png_unf_fifo import png_unf_pkg::*; #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] store_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = store_q[rd_ptr_q];

  // Pointer and fill-level update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== design/png_unf_front.sv =====
module png_unf_front import png_unf_pkg::*; #(
  parameter int unsigned MaxWidth = 8192
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_write_i,
  input  logic [CfgIndexW-1:0]                cfg_index_i,
  input  logic [CfgDataW-1:0]                 cfg_data_i,
  input  logic                                accept_i,
  input  in_item_t                            item_i,
  output job_t                                job_o,
  output logic [$clog2(MaxWidth * 4)-1:0]     job_addr_o
);

  localparam int unsigned Depth = MaxWidth * 4;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned LenW  = $clog2(Depth + 1);
  localparam int unsigned WideW = (LenW > ImgWidthW) ? LenW : ImgWidthW;

  logic [ImgWidthW-1:0]  width_q;
  logic [ImgHeightW-1:0] height_q;
  logic [BppW-1:0]       bpp_q;

  logic [AddrW-1:0]      col_q, col_d;
  logic [1:0]            mod3_q, mod3_d;
  logic [ImgHeightW-1:0] row_q, row_d;
  filter_e               filt_q, filt_d;
  logic                  await_q, await_d;
  logic                  err_q, err_d;

  logic                  bpp3;
  logic [WideW-1:0]      w_wide;
  logic [LenW-1:0]       w_sat;
  logic [LenW-1:0]       row_len;
  logic [ImgHeightW-1:0] h_eff;

  logic [AddrW-1:0]      col;
  logic [1:0]            mod3;
  logic [ImgHeightW-1:0] row;
  filter_e               filt;
  logic                  await_flt;
  logic                  err;
  logic [LenW-1:0]       x_inc;
  logic                  row_end;
  logic                  last_row;
  logic                  bad;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 14'd1;
      height_q <= 16'd1;
      bpp_q    <= 3'd4;
    end else if (cfg_write_i) begin
      case (cfg_index_i)
        CFG_IMAGE_WIDTH:     width_q  <= cfg_data_i[ImgWidthW-1:0];
        CFG_IMAGE_HEIGHT:    height_q <= cfg_data_i[ImgHeightW-1:0];
        CFG_BYTES_PER_PIXEL: bpp_q    <= cfg_data_i[BppW-1:0];
        default: ;
      endcase
    end
  end

  // Effective geometry: zero sizes act as one, width saturates at the line store size.
  always_comb begin
    bpp3   = (bpp_q == BppRgb);
    w_wide = WideW'((width_q == '0) ? 14'd1 : width_q);
    if (w_wide > WideW'(MaxWidth)) begin
      w_wide = WideW'(MaxWidth);
    end
    w_sat   = LenW'(w_wide);
    row_len = bpp3 ? (w_sat + (w_sat << 1)) : (w_sat << 2);
    h_eff   = (height_q == '0) ? 16'd1 : height_q;
  end

  // Classification of one accepted item and the counter update it causes.
  always_comb begin
    col       = item_i.frame_start ? '0 : col_q;
    mod3      = item_i.frame_start ? '0 : mod3_q;
    row       = item_i.frame_start ? '0 : row_q;
    filt      = item_i.frame_start ? FILT_NONE : filt_q;
    await_flt = item_i.frame_start ? 1'b1 : await_q;
    err       = item_i.frame_start ? 1'b0 : err_q;

    x_inc    = LenW'(col) + 1'b1;
    row_end  = (x_inc >= row_len);
    last_row = ({1'b0, row} + 17'd1) >= {1'b0, h_eff};
    bad      = !err && await_flt && (item_i.filtered_byte > ByteW'(FILT_PAETH));

    col_d   = col_q;
    mod3_d  = mod3_q;
    row_d   = row_q;
    filt_d  = filt_q;
    await_d = await_q;
    err_d   = err_q;

    job_o.kind      = JOB_PIXEL;
    job_o.data      = item_i.filtered_byte;
    job_o.filter    = filt;
    job_o.lane      = bpp3 ? mod3 : col[1:0];
    job_o.first_row = (row == '0);
    job_o.eoi       = row_end && last_row;
    job_o.alpha     = bpp3 && (mod3 == 2'd2);
    job_addr_o      = col;

    if (!err && await_flt && !bad) begin
      job_o.kind = JOB_CLEAR;
    end else if (err || bad) begin
      job_o.kind = JOB_ERROR;
    end

    if (accept_i) begin
      col_d   = col;
      mod3_d  = mod3;
      row_d   = row;
      filt_d  = filt;
      await_d = await_flt;
      err_d   = err || bad;
      if (job_o.kind == JOB_CLEAR) begin
        filt_d  = filter_e'(item_i.filtered_byte[2:0]);
        await_d = 1'b0;
        col_d   = '0;
        mod3_d  = '0;
      end else if (job_o.kind == JOB_PIXEL) begin
        if (row_end) begin
          col_d   = '0;
          mod3_d  = '0;
          await_d = 1'b1;
          row_d   = last_row ? '0 : row + 1'b1;
        end else begin
          col_d  = AddrW'(x_inc);
          mod3_d = (mod3 == 2'd2) ? 2'd0 : mod3 + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      mod3_q  <= '0;
      row_q   <= '0;
      filt_q  <= FILT_NONE;
      await_q <= 1'b1;
      err_q   <= 1'b0;
    end else begin
      col_q   <= col_d;
      mod3_q  <= mod3_d;
      row_q   <= row_d;
      filt_q  <= filt_d;
      await_q <= await_d;
      err_q   <= err_d;
    end
  end

endmodule

// ===== design/png_unf_back.sv =====
module png_unf_back import png_unf_pkg::*; #(
  parameter int unsigned MaxWidth = 8192
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            job_valid_i,
  input  job_t                            job_i,
  input  logic [$clog2(MaxWidth * 4)-1:0] job_addr_i,
  output logic                            job_pop_o,
  output logic                            out_push_o,
  output out_item_t                       out_item_o,
  input  logic                            out_full_i
);

  localparam int unsigned Depth = MaxWidth * 4;
  localparam int unsigned AddrW = $clog2(Depth);

  // Paeth predictor on the left, above and above-left bytes.
  function automatic logic [ByteW-1:0] paeth(input logic [ByteW-1:0] a,
                                             input logic [ByteW-1:0] b,
                                             input logic [ByteW-1:0] c);
    logic [ByteW-1:0] pa;
    logic [ByteW-1:0] pb;
    logic [ByteW+1:0] sab;
    logic [ByteW+1:0] s2c;
    logic [ByteW+1:0] pc;
    pa  = (b > c) ? b - c : c - b;
    pb  = (a > c) ? a - c : c - a;
    sab = {2'b00, a} + {2'b00, b};
    s2c = {1'b0, c, 1'b0};
    pc  = (sab > s2c) ? sab - s2c : s2c - sab;
    if ((pa <= pb) && ({2'b00, pa} <= pc)) begin
      return a;
    end else if ({2'b00, pb} <= pc) begin
      return b;
    end
    return c;
  endfunction

  logic [ByteW-1:0] line_mem [Depth];
  logic [ByteW-1:0] rdata_q;

  logic             b_valid_q;
  job_t             b_job_q;
  logic [AddrW-1:0] b_addr_q;
  logic             b_half_q;

  logic [ByteW-1:0] left_q   [4];
  logic [ByteW-1:0] upleft_q [4];

  logic [ByteW-1:0] nb_a, nb_b, nb_c;
  logic [ByteW-1:0] pred;
  logic [ByteW:0]   avg_sum;
  logic [ByteW-1:0] value;
  logic             b_done;
  logic             advance;
  logic             pix_done;

  // Reconstruction of the byte held in the compute stage.
  always_comb begin
    nb_a    = left_q[b_job_q.lane];
    nb_c    = upleft_q[b_job_q.lane];
    nb_b    = b_job_q.first_row ? '0 : rdata_q;
    avg_sum = {1'b0, nb_a} + {1'b0, nb_b};
    case (b_job_q.filter)
      FILT_SUB:   pred = nb_a;
      FILT_UP:    pred = nb_b;
      FILT_AVG:   pred = avg_sum[ByteW:1];
      FILT_PAETH: pred = paeth(nb_a, nb_b, nb_c);
      default:    pred = '0;
    endcase
    value = b_job_q.data + pred;
  end

  // Result emission; an RGB pixel's third byte is followed by an alpha byte.
  always_comb begin
    out_push_o = 1'b0;
    b_done     = 1'b0;
    out_item_o = '{pixel_byte: value, last_in_run: !b_job_q.alpha,
                   end_of_image: b_job_q.eoi && !b_job_q.alpha, bad_filter: 1'b0};
    if (b_half_q) begin
      out_item_o = '{pixel_byte: AlphaOpaque, last_in_run: 1'b1,
                     end_of_image: b_job_q.eoi, bad_filter: 1'b0};
    end
    case (b_job_q.kind)
      JOB_CLEAR: begin
        b_done = b_valid_q;
      end
      JOB_ERROR: begin
        out_item_o = '{pixel_byte: '0, last_in_run: 1'b1,
                       end_of_image: 1'b0, bad_filter: 1'b1};
        out_push_o = b_valid_q && !out_full_i;
        b_done     = out_push_o;
      end
      JOB_PIXEL: begin
        out_push_o = b_valid_q && !out_full_i;
        b_done     = out_push_o && (!b_job_q.alpha || b_half_q);
      end
      default: begin
        b_done = b_valid_q;
      end
    endcase
    pix_done  = b_done && (b_job_q.kind == JOB_PIXEL);
    advance   = !b_valid_q || b_done;
    job_pop_o = advance && job_valid_i;
  end

  // Stage register in front of the compute step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      b_half_q  <= 1'b0;
    end else begin
      if (advance) begin
        b_valid_q <= job_valid_i;
      end
      if (b_done) begin
        b_half_q <= 1'b0;
      end else if (out_push_o && (b_job_q.kind == JOB_PIXEL) && b_job_q.alpha) begin
        b_half_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      b_job_q  <= job_i;
      b_addr_q <= job_addr_i;
    end
  end

  // Line store: written as each byte completes, read as its job enters the compute stage.
  always_ff @(posedge clk_i) begin
    if (pix_done) begin
      line_mem[b_addr_q] <= value;
    end
    if (job_pop_o) begin
      rdata_q <= line_mem[job_addr_i];
    end
  end

  // Left and above-left bytes per lane, cleared at each row start.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        left_q[i]   <= '0;
        upleft_q[i] <= '0;
      end
    end else if (b_done && (b_job_q.kind == JOB_CLEAR)) begin
      for (int i = 0; i < 4; i++) begin
        left_q[i]   <= '0;
        upleft_q[i] <= '0;
      end
    end else if (pix_done) begin
      left_q[b_job_q.lane]   <= value;
      upleft_q[b_job_q.lane] <= nb_b;
    end
  end

endmodule
